/* rtl/hpid_pkg.sv */
// hpid_pkg: shared widths, constants, register indexes and inter-stage structs
// for the heading PID turn controller. No dependencies.
package hpid_pkg;

	localparam int HeadW   = 16;
	localparam int ErrW    = 18;
	localparam int ChgW    = 19;
	localparam int SumW    = 32;
	localparam int GainW   = 32;
	localparam int TgtW    = 17;
	localparam int LimW    = 17;
	localparam int DriveW  = 16;
	localparam int IdxW    = 3;
	localparam int CfgW    = 32;
	localparam int FracBits = 24;

	localparam int HalfTurn = 18000;
	localparam int FullTurn = 36000;

	localparam logic signed [TgtW-1:0] TargetRst   = '0;
	localparam logic [GainW-1:0]       PropGainRst = 32'd67108864;
	localparam logic [GainW-1:0]       IntegGainRst = 32'd168;
	localparam logic [GainW-1:0]       DerivGainRst = 32'd13421773;
	localparam logic [LimW-1:0]        IntegWinRst = 17'd5000;
	localparam logic [LimW-1:0]        ErrLimRst   = 17'd150;
	localparam logic [LimW-1:0]        RateLimRst  = 17'd200;

	typedef enum logic [IdxW-1:0] {
		REG_TARGET     = 3'd0,
		REG_PROP_GAIN  = 3'd1,
		REG_INTEG_GAIN = 3'd2,
		REG_DERIV_GAIN = 3'd3,
		REG_INTEG_WIN  = 3'd4,
		REG_ERR_LIM    = 3'd5,
		REG_RATE_LIM   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [TgtW-1:0] target;
		logic [GainW-1:0]       prop_gain;
		logic [GainW-1:0]       integ_gain;
		logic [GainW-1:0]       deriv_gain;
		logic [LimW-1:0]        integ_win;
		logic [LimW-1:0]        err_lim;
		logic [LimW-1:0]        rate_lim;
	} cfg_t;

	// error stage -> multiply stage
	typedef struct packed {
		logic                   valid;
		logic                   done;
		logic signed [ErrW-1:0] err;
		logic signed [ChgW-1:0] chg;
		logic signed [SumW-1:0] esum;
	} s1_t;

endpackage

/* rtl/hpid_state.sv */
// hpid_state: heading wrap, error, integral and turn state; registers stage 1.
// Depends on hpid_pkg.
module hpid_state (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hpid_pkg::cfg_t             cfg,
	input  logic                       in_acc,
	input  logic                       adv,
	input  logic [hpid_pkg::HeadW-1:0] heading,
	input  logic                       start_req,
	output hpid_pkg::s1_t              s1
);
	import hpid_pkg::*;

	logic                   active_q;
	logic                   wrap_q;
	logic signed [ErrW-1:0] prev_q;
	logic signed [SumW-1:0] esum_q;

	logic signed [ErrW-1:0]   raw_diff;
	logic [ErrW-1:0]          raw_abs;
	logic                     wrap_start;
	logic                     wrap_use;
	logic signed [ErrW-1:0]   tgt_w;
	logic signed [ErrW-1:0]   sen_w;
	logic signed [ErrW:0]     diff;
	logic signed [ErrW-1:0]   err;
	logic signed [ChgW-1:0]   chg;
	logic [ErrW-1:0]          abs_e;
	logic [ChgW-1:0]          abs_c;
	logic signed [SumW:0]     sum_ext;
	logic signed [SumW-1:0]   sum_sat;
	logic signed [SumW-1:0]   esum_nxt;
	logic                     done;

	always_comb begin
		raw_diff   = ErrW'(cfg.target) - $signed({2'b00, heading});
		raw_abs    = raw_diff[ErrW-1] ? ErrW'(-raw_diff) : ErrW'(raw_diff);
		wrap_start = raw_abs > ErrW'(HalfTurn);
		wrap_use   = start_req ? wrap_start : wrap_q;

		tgt_w = ErrW'(cfg.target);
		if (wrap_use && (cfg.target > TgtW'(HalfTurn))) begin
			tgt_w = tgt_w - ErrW'(FullTurn);
		end
		sen_w = $signed({2'b00, heading});
		if (wrap_use && (heading > HeadW'(HalfTurn))) begin
			sen_w = sen_w - ErrW'(FullTurn);
		end

		// saturate the error to 18 bits signed
		diff = (ErrW+1)'(tgt_w) - (ErrW+1)'(sen_w);
		if (diff > (ErrW+1)'(131071)) begin
			err = ErrW'(131071);
		end else if (diff < -(ErrW+1)'(131072)) begin
			err = ErrW'(-131072);
		end else begin
			err = diff[ErrW-1:0];
		end

		chg   = ChgW'(err) - ChgW'(prev_q);
		abs_e = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
		abs_c = chg[ChgW-1] ? ChgW'(-chg) : ChgW'(chg);

		sum_ext = (SumW+1)'(esum_q) + (SumW+1)'(err);
		if (sum_ext[SumW] != sum_ext[SumW-1]) begin
			sum_sat = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SumW-1:0];
		end
		esum_nxt = ({1'b0, abs_e} < {2'b00, cfg.integ_win}) ? sum_sat : '0;

		done = ({1'b0, abs_e} < {2'b00, cfg.err_lim}) &&
		       (abs_c < {2'b00, cfg.rate_lim});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			wrap_q   <= 1'b0;
			prev_q   <= '0;
			esum_q   <= '0;
		end else if (in_acc) begin
			if (start_req) begin
				wrap_q   <= wrap_start;
				prev_q   <= err;
				esum_q   <= '0;
				active_q <= 1'b1;
			end else if (active_q) begin
				prev_q <= err;
				esum_q <= esum_nxt;
				if (done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (adv) begin
			s1.valid <= in_acc && !start_req && active_q;
			s1.done  <= done;
			s1.err   <= err;
			s1.chg   <= chg;
			s1.esum  <= esum_nxt;
		end
	end

endmodule

/* rtl/hpid_mac.sv */
// hpid_mac: gain products (stage 2), sum with truncation toward zero and
// drive saturation into the result register (stage 3). Depends on hpid_pkg.
module hpid_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hpid_pkg::cfg_t                     cfg,
	input  logic                               adv,
	input  hpid_pkg::s1_t                      s1,
	output logic                               out_valid,
	output logic signed [hpid_pkg::DriveW-1:0] left_drive,
	output logic signed [hpid_pkg::DriveW-1:0] right_drive,
	output logic                               done_res
);
	import hpid_pkg::*;

	localparam int PW  = GainW + 1 + ErrW;
	localparam int IW  = GainW + 1 + SumW;
	localparam int DW  = GainW + 1 + ChgW;
	localparam int TW  = IW + 1;
	localparam int QW  = TW - FracBits;

	logic                 valid_s2;
	logic                 done_s2;
	logic signed [PW-1:0] prod_p_s2;
	logic signed [IW-1:0] prod_i_s2;
	logic signed [DW-1:0] prod_d_s2;

	logic signed [TW-1:0]     total;
	logic signed [QW-1:0]     q_floor;
	logic signed [QW-1:0]     q;
	logic signed [DriveW-1:0] left_sat;
	logic signed [DriveW-1:0] right_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s2   <= s1.done;
			prod_p_s2 <= $signed({1'b0, cfg.prop_gain}) * $signed(s1.err);
			prod_i_s2 <= $signed({1'b0, cfg.integ_gain}) * $signed(s1.esum);
			prod_d_s2 <= $signed({1'b0, cfg.deriv_gain}) * $signed(s1.chg);
		end
	end

	always_comb begin
		total = {{(TW-PW){prod_p_s2[PW-1]}}, prod_p_s2}
		      + {{(TW-IW){prod_i_s2[IW-1]}}, prod_i_s2}
		      + {{(TW-DW){prod_d_s2[DW-1]}}, prod_d_s2};
		q_floor = total[TW-1:FracBits];
		// floor -> truncation toward zero for negative sums with a fraction
		q = (total[TW-1] && (|total[FracBits-1:0])) ? q_floor + QW'(1) : q_floor;
		if (q > QW'(32767)) begin
			left_sat = DriveW'(32767);
		end else if (q < -QW'(32768)) begin
			left_sat = DriveW'(-32768);
		end else begin
			left_sat = q[DriveW-1:0];
		end
		right_sat = (left_sat == DriveW'(-32768)) ? DriveW'(32767) : -left_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_drive  <= left_sat;
			right_drive <= right_sat;
			done_res    <= done_s2;
		end
	end

endmodule

/* rtl/heading_pid_turn_controller_top.sv */
// Heading PID turn controller, top level: configuration registers, stall
// control, error/state stage and multiply/sum stage. Depends on hpid_pkg.
// A sample accepted into the stage 1 register passes through the stage 2 register into the result register.
// Throughput: one sample per cycle; a held result stalls the whole pipeline.
// Start samples and idle samples leave a bubble and no result.
// Reset (arst_n low, async): gains/limits to defaults, turn inactive, pipe empty.
module heading_pid_turn_controller_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               wr_en,
	input  logic [hpid_pkg::IdxW-1:0]          wr_index,
	input  logic [hpid_pkg::CfgW-1:0]          wr_data,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [hpid_pkg::HeadW-1:0]         heading,
	input  logic                               start_req,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [hpid_pkg::DriveW-1:0] left_drive,
	output logic signed [hpid_pkg::DriveW-1:0] right_drive,
	output logic                               done_res
);
	import hpid_pkg::*;

	cfg_t cfg_q;
	s1_t  s1;
	logic adv;
	logic in_acc;

	// The pipe moves as a unit: it only freezes while a finished result sits
	// in the output register and the consumer stalls it. Bubbles ahead of it
	// freeze too, which keeps the control trivial.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// Config registers; index 7 is unmapped and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target     <= TargetRst;
			cfg_q.prop_gain  <= PropGainRst;
			cfg_q.integ_gain <= IntegGainRst;
			cfg_q.deriv_gain <= DerivGainRst;
			cfg_q.integ_win  <= IntegWinRst;
			cfg_q.err_lim    <= ErrLimRst;
			cfg_q.rate_lim   <= RateLimRst;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TARGET:     cfg_q.target     <= wr_data[TgtW-1:0];
				REG_PROP_GAIN:  cfg_q.prop_gain  <= wr_data[GainW-1:0];
				REG_INTEG_GAIN: cfg_q.integ_gain <= wr_data[GainW-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain <= wr_data[GainW-1:0];
				REG_INTEG_WIN:  cfg_q.integ_win  <= wr_data[LimW-1:0];
				REG_ERR_LIM:    cfg_q.err_lim    <= wr_data[LimW-1:0];
				REG_RATE_LIM:   cfg_q.rate_lim   <= wr_data[LimW-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: wrap, error, integral, done flag; turn state updates on accept.
	hpid_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_acc    (in_acc),
		.adv       (adv),
		.heading   (heading),
		.start_req (start_req),
		.s1        (s1)
	);

	// Stages 2-3: three Q8.24 products, exact sum, truncate, saturate drives.
	hpid_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.adv         (adv),
		.s1          (s1),
		.out_valid   (out_valid),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.done_res    (done_res)
	);

endmodule

/* rtl/hpid_checker.sv */
// hpid_checker: port-level assertions for the turn controller, bound to the
// top level. Depends on the top level's port list only.
module hpid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] heading,
	input logic        start_req,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] left_drive,
	input logic [15:0] right_drive,
	input logic        done_res
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_drive) &&
		$stable(right_drive) && $stable(done_res))
		else $error("result changed while stalled");

	// a stalled sample transaction stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(heading) && $stable(start_req))
		else $error("sample changed while stalled");

	// right drive is the saturated negation of left
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((left_drive == 16'h8000) ? (right_drive == 16'h7fff) :
		(right_drive == 16'(-left_drive))))
		else $error("right drive is not negated left");

	// input side only backs up behind a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a free output side leaves the input unstalled in the next cycle unless out_valid is or was high
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> !in_stall || $past(out_valid) || out_valid)
		else $error("input stalled with output free");

endmodule

bind heading_pid_turn_controller_top hpid_checker u_hpid_checker (.*);

/* dv/tb_heading_pid_turn_controller_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for heading_pid_turn_controller_top: directed and random heading
// transactions are checked against an in-bench PID turn predictor. Needs hpid_pkg and RTL.
module tb_heading_pid_turn_controller_top;
	import hpid_pkg::*;

	// one heading transaction as offered on the sample channel
	typedef struct {
		logic [HeadW-1:0] heading;
		logic             start;
	} sample_t;

	// one expected result transaction
	typedef struct {
		logic signed [DriveW-1:0] left;
		logic signed [DriveW-1:0] right;
		logic                     done;
	} drive_t;

	typedef enum {CFG_DEFAULT, CFG_TOP, CFG_ZERO, CFG_MIXED} cfg_flavor_t;

	localparam logic [IdxW-1:0] IdxUnused = 3'd7;   // no register here, write is dropped
	localparam int     PhaseCount    = 13;
	localparam int     PhaseItems    = 40;
	localparam int     PressurePhase = 3;
	localparam int     QuietPhase    = 6;
	localparam int     HoldCycles    = 80;
	localparam int     DrainCycles   = 8;             // extra wait after the last result, as margin
	localparam int     IdlePct       = 29;
	localparam longint SumMax        = (longint'(1) <<< (SumW - 1)) - 1;
	localparam longint SumMin        = -(longint'(1) <<< (SumW - 1));
	localparam longint ErrMax        = (longint'(1) <<< (ErrW - 1)) - 1;
	localparam longint ErrMin        = -(longint'(1) <<< (ErrW - 1));
	localparam longint DriveMax      = (longint'(1) <<< (DriveW - 1)) - 1;
	localparam longint DriveMin      = -(longint'(1) <<< (DriveW - 1));

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     wr_en     = 1'b0;
	logic [IdxW-1:0]          wr_index  = '0;
	logic [CfgW-1:0]          wr_data   = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic [HeadW-1:0]         heading   = '0;
	logic                     start_req = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DriveW-1:0] left_drive;
	logic signed [DriveW-1:0] right_drive;
	logic                     done_res;

	// predictor copy of the registers and the turn state
	cfg_t   model_cfg;
	logic   turn_active;
	logic   wrap_mode;
	longint prev_err;
	longint err_sum;

	sample_t heading_backlog[$];   // transactions waiting for the driver
	drive_t  expected_drives[$];   // predicted results, oldest first
	int      mismatch_count = 0;
	int      tx_idle_pct    = IdlePct;
	int      rx_stall_pct   = IdlePct;
	logic    rx_hold        = 1'b0;
	int      phase_no       = 0;

	heading_pid_turn_controller_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.heading     (heading),
		.start_req   (start_req),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.done_res    (done_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// error against the target; in wrap mode anything past half a turn is shifted down a full turn
	function automatic longint heading_error(logic [HeadW-1:0] hd);
		longint sensor;
		longint aim;
		sensor = longint'(hd);
		aim    = longint'($signed(model_cfg.target));
		if (wrap_mode && sensor > HalfTurn)
			sensor -= FullTurn;
		if (wrap_mode && aim > HalfTurn)
			aim -= FullTurn;
		return clamp(aim - sensor, ErrMin, ErrMax);
	endfunction

	// exact Q8.24 product, wide enough for a full-scale gain times a full-scale sum
	function automatic logic signed [95:0] gain_term(logic [GainW-1:0] g, longint v);
		logic signed [95:0] gs;
		logic signed [95:0] vs;
		gs = $signed({64'd0, g});
		vs = v;
		return gs * vs;
	endfunction

	function automatic void predict_turn_step(logic [HeadW-1:0] hd, logic st);
		longint             e;
		longint             chg;
		longint             q;
		longint             left;
		logic signed [95:0] acc;
		drive_t             d;
		if (st) begin
			// wrap is decided once, from the raw target and the start heading
			wrap_mode   = magnitude(longint'($signed(model_cfg.target)) - longint'(hd)) > HalfTurn;
			prev_err    = heading_error(hd);
			err_sum     = 0;
			turn_active = 1'b1;
			return;
		end
		if (!turn_active)
			return;
		e   = heading_error(hd);
		chg = e - prev_err;
		// integral runs only inside the window, otherwise it is dumped
		if (magnitude(e) < longint'(model_cfg.integ_win))
			err_sum = clamp(err_sum + e, SumMin, SumMax);
		else
			err_sum = 0;
		acc = gain_term(model_cfg.prop_gain, e) + gain_term(model_cfg.integ_gain, err_sum)
			+ gain_term(model_cfg.deriv_gain, chg);
		// drop the fraction, rounding toward zero
		q = (acc < 0) ? -longint'((-acc) >>> FracBits) : longint'(acc >>> FracBits);
		left    = clamp(q, DriveMin, DriveMax);
		d.left  = left[DriveW-1:0];
		d.right = DriveW'(clamp(-left, DriveMin, DriveMax));
		d.done  = magnitude(e) < longint'(model_cfg.err_lim)
			&& magnitude(chg) < longint'(model_cfg.rate_lim);
		prev_err = e;
		if (d.done)
			turn_active = 1'b0;
		expected_drives.push_back(d);
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t ns: %s", $time, what);
	endtask

	// result monitor: compares each accepted result transaction, then picks the next stall
	always @(posedge clk) begin
		drive_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_drives.size() == 0) begin
					report_mismatch($sformatf("unexpected result left %0d right %0d done %0b",
						left_drive, right_drive, done_res));
				end else begin
					want = expected_drives.pop_front();
					if (left_drive !== want.left)
						report_mismatch($sformatf("left_drive %0d, predicted %0d",
							left_drive, want.left));
					if (right_drive !== want.right)
						report_mismatch($sformatf("right_drive %0d, predicted %0d",
							right_drive, want.right));
					if (done_res !== want.done)
						report_mismatch($sformatf("done_res %0b, predicted %0b",
							done_res, want.done));
				end
			end
			out_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
		end
	end

	// sample driver: predicts on acceptance, holds a stalled transaction unchanged
	always @(posedge clk) begin
		sample_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_turn_step(heading, start_req);
			if (!in_valid || !in_stall) begin
				if (heading_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = heading_backlog.pop_front();
					in_valid  <= 1'b1;
					heading   <= nxt.heading;
					start_req <= nxt.start;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic void queue_sample(int h, logic st);
		sample_t s;
		s.heading = h[HeadW-1:0];
		s.start   = st;
		heading_backlog.push_back(s);
	endfunction

	// a start, a noisy approach toward the target, then two samples on it so it can settle
	function automatic int queue_turn();
		int aim;
		int start_h;
		int offset;
		int steps;
		int h;
		aim     = ((int'($signed(model_cfg.target)) % FullTurn) + FullTurn) % FullTurn;
		start_h = $urandom_range(FullTurn - 1);
		offset  = start_h - aim;
		if (offset > HalfTurn)
			offset -= FullTurn;
		else if (offset < -HalfTurn)
			offset += FullTurn;
		steps = $urandom_range(14, 2);
		queue_sample(start_h, 1'b1);
		for (int k = 1; k <= steps; k++) begin
			h = aim + offset * (steps - k) / steps + int'($urandom_range(60)) - 30;
			queue_sample(((h % FullTurn) + FullTurn) % FullTurn, 1'b0);
		end
		queue_sample(aim, 1'b0);
		queue_sample(aim, 1'b0);
		return steps + 3;
	endfunction

	// stray samples and starts, a few with out-of-range headings
	function automatic int queue_noise();
		int n;
		int h;
		n = $urandom_range(4, 1);
		for (int k = 0; k < n; k++) begin
			h = ($urandom_range(99) < 8) ? int'($urandom_range(16'hFFFF))
				: int'($urandom_range(FullTurn - 1));
			queue_sample(h, $urandom_range(99) < 12);
		end
		return n;
	endfunction

	function automatic cfg_t pick_config(cfg_flavor_t flavor);
		cfg_t c;
		case (flavor)
			CFG_DEFAULT: begin
				c = '{TargetRst, PropGainRst, IntegGainRst, DerivGainRst,
					IntegWinRst, ErrLimRst, RateLimRst};
			end
			CFG_TOP: begin
				c = '{'0, '1, '1, '1, '1, '1, '1};
				case ($urandom_range(3))
					0: c.target = TgtW'(FullTurn);
					1: c.target = TgtW'(-FullTurn);
					2: c.target = {1'b0, {(TgtW-1){1'b1}}};
					default: c.target = {1'b1, {(TgtW-1){1'b0}}};
				endcase
			end
			CFG_ZERO: begin
				c = '{'0, '0, '0, '0, '0, '0, '0};
			end
			default: begin
				c.target     = ($urandom_range(99) < 10) ? TgtW'($urandom)
					: TgtW'($urandom_range(2 * FullTurn) - FullTurn);
				c.prop_gain  = ($urandom_range(99) < 15) ? $urandom : $urandom_range(32'h0800_0000);
				c.integ_gain = ($urandom_range(99) < 15) ? $urandom : $urandom_range(32'h0001_0000);
				c.deriv_gain = ($urandom_range(99) < 15) ? $urandom : $urandom_range(32'h0200_0000);
				c.integ_win  = ($urandom_range(99) < 10) ? LimW'($urandom) : LimW'($urandom_range(8000));
				c.err_lim    = ($urandom_range(99) < 10) ? LimW'($urandom) : LimW'($urandom_range(400));
				c.rate_lim   = ($urandom_range(99) < 10) ? LimW'($urandom) : LimW'($urandom_range(600));
			end
		endcase
		return c;
	endfunction

	// one register write; the register takes the value at the next edge
	task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] word);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= word;
		@(posedge clk);
		case (idx)
			REG_TARGET:     model_cfg.target     = word[TgtW-1:0];
			REG_PROP_GAIN:  model_cfg.prop_gain  = word;
			REG_INTEG_GAIN: model_cfg.integ_gain = word;
			REG_DERIV_GAIN: model_cfg.deriv_gain = word;
			REG_INTEG_WIN:  model_cfg.integ_win  = word[LimW-1:0];
			REG_ERR_LIM:    model_cfg.err_lim    = word[LimW-1:0];
			REG_RATE_LIM:   model_cfg.rate_lim   = word[LimW-1:0];
			default: ;
		endcase
	endtask

	// narrow registers get junk above their width, which must be dropped
	task automatic write_config(cfg_t c);
		logic [CfgW-1:0] junk;
		junk = $urandom;
		write_reg(REG_TARGET,     {junk[CfgW-1:TgtW], c.target});
		write_reg(REG_PROP_GAIN,  c.prop_gain);
		write_reg(REG_INTEG_GAIN, c.integ_gain);
		write_reg(REG_DERIV_GAIN, c.deriv_gain);
		write_reg(REG_INTEG_WIN,  {junk[CfgW-1:LimW], c.integ_win});
		write_reg(REG_ERR_LIM,    {junk[CfgW-1:LimW], c.err_lim});
		write_reg(REG_RATE_LIM,   {junk[CfgW-1:LimW], c.rate_lim});
		write_reg(IdxUnused,      $urandom);
		wr_en <= 1'b0;
	endtask

	// wait until every transaction is through and the pipe has drained
	task automatic settle();
		do
			@(negedge clk);
		while (heading_backlog.size() != 0 || in_valid || expected_drives.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		cfg_t c;
		int   queued;
		model_cfg   = pick_config(CFG_DEFAULT);
		turn_active = 1'b0;
		wrap_mode   = 1'b0;
		prev_err    = 0;
		err_sum     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed transactions under the reset configuration
		@(negedge clk);
		queue_sample(100, 1'b0);     // no turn yet: ignored
		queue_sample(0, 1'b1);       // start on target, no wrap
		queue_sample(40, 1'b0);      // small error and change: settles at once
		queue_sample(500, 1'b0);     // after settling: ignored
		queue_sample(35999, 1'b1);   // far side of north: wrap mode
		queue_sample(35000, 1'b0);
		queue_sample(18000, 1'b0);   // exactly half a turn is not shifted
		queue_sample(18001, 1'b0);   // just past it is
		queue_sample(65535, 1'b0);   // out-of-range heading, drive saturates
		queue_sample(32768, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(1000, 1'b1);    // restart while a turn is running
		queue_sample(4000, 1'b1);    // and again
		queue_sample(5000, 1'b0);    // on the integral window edge: cleared
		queue_sample(4999, 1'b0);    // just inside: accumulates
		queue_sample(2000, 1'b0);
		queue_sample(300, 1'b0);
		queue_sample(100, 1'b0);
		queue_sample(100, 1'b0);     // settles
		queue_sample(18000, 1'b1);   // start exactly half a turn away: no wrap
		queue_sample(18001, 1'b0);
		queue_sample(18001, 1'b1);   // start just past half a turn: wrap
		queue_sample(0, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(200, 1'b1);     // left running into the next target
		settle();

		// random phases; the first two hold the gains and limits at an extreme
		for (int p = 1; p <= PhaseCount; p++) begin
			phase_no = p;
			c = pick_config(p == 1 ? CFG_TOP : p == 2 ? CFG_ZERO
				: p == PhaseCount ? CFG_DEFAULT : CFG_MIXED);
			if (p == PressurePhase)
				c.err_lim = '0;   // never settles, so every non-start sample after a start yields a result
			write_config(c);
			tx_idle_pct  <= (p == QuietPhase) ? 0 : IdlePct;
			rx_stall_pct <= (p == QuietPhase) ? 0 : IdlePct;
			@(negedge clk);
			queued = 0;
			while (queued < PhaseItems) begin
				if ($urandom_range(99) < 75)
					queued += queue_turn();
				else
					queued += queue_noise();
			end
			settle();
		end

		if (mismatch_count == 0)
			$display("heading_pid_turn_controller_top verification clean");
		else
			$display("heading_pid_turn_controller_top verification failed");
		$finish;
	end

	// receiver goes quiet for a long stretch so the pipe backs up into in_stall
	initial begin
		wait (phase_no == PressurePhase);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("heading_pid_turn_controller_top verification failed");
		$finish;
	end

endmodule
